### rtl/pfta_pkg.sv
// ----------------------------------------------------------------------------
// Page frame table allocator package
// Shared types, command and register codes, and default sizes.
// ----------------------------------------------------------------------------
package pfta_pkg;

    localparam int DEF_MAX_FRAMES     = 64;
    localparam int DEF_MAX_PAGE_BYTES = 4096;
    localparam int DEF_PID_BITS       = 16;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SIZE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 4'd1;

    localparam logic [12:0] PAGE_SIZE_RESET   = 13'd64;
    localparam logic [6:0]  FRAME_COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_FIND    = 2'd0,
        CMD_OCCUPY  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_COUNT   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] process_id;
        logic [5:0]  frame_index;
        logic [12:0] fill_bytes;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  found_frame;
        logic [12:0] hole_start;
        logic [6:0]  free_frames;
    } rsp_t;

endpackage

### rtl/pfta_frame_mem.sv
// ----------------------------------------------------------------------------
// Frame table memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module pfta_frame_mem
    import pfta_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_FRAMES,
    parameter int WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/pfta_ctrl.sv
// ----------------------------------------------------------------------------
// Frame table sequencer
// Clears the table after reset, scans it one frame per cycle for find and
// count, and updates single frames through a read-modify-write.
// ----------------------------------------------------------------------------
module pfta_ctrl
    import pfta_pkg::*;
#(
    parameter int MAX_FRAMES     = DEF_MAX_FRAMES,
    parameter int MAX_PAGE_BYTES = DEF_MAX_PAGE_BYTES,
    parameter int PID_BITS       = DEF_PID_BITS,
    localparam int AW    = $clog2(MAX_FRAMES),
    localparam int CNT_W = $clog2(MAX_FRAMES + 1),
    localparam int OFF_W = $clog2(MAX_PAGE_BYTES + 1),
    localparam int E_W   = PID_BITS + OFF_W + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    input  logic [OFF_W-1:0] page_lim,
    input  logic [CNT_W-1:0] scan_n,
    output logic             res_valid,
    input  logic             res_ready,
    output rsp_t             res,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [E_W-1:0]   mem_wdata,
    output logic             mem_re,
    output logic [AW-1:0]    mem_raddr,
    input  logic [E_W-1:0]   mem_rdata
);

    localparam int SUM_W = ((OFF_W > 13) ? OFF_W : 13) + 1;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic                have_free_reg, have_free_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    cmd_t                cmd_reg, cmd_next;
    logic [PID_BITS-1:0] pid_reg, pid_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [12:0]         fill_reg, fill_next;
    logic [AW-1:0]       chk_reg, chk_next;
    logic [AW-1:0]       first_free_reg, first_free_next;
    rsp_t                res_reg, res_next;

    logic [PID_BITS-1:0] rd_owner;
    logic [OFF_W-1:0]    rd_offset;
    logic                rd_partial;
    logic                rd_free;
    logic                idx_ok;
    logic                hit;
    logic                scan_end;
    logic [SUM_W-1:0]    sum;
    logic [OFF_W-1:0]    new_offset;

    assign rd_owner   = mem_rdata[E_W-1 -: PID_BITS];
    assign rd_offset  = mem_rdata[OFF_W+1:2];
    assign rd_partial = mem_rdata[1];
    assign rd_free    = mem_rdata[0];

    assign idx_ok   = (32'(req.frame_index) < MAX_FRAMES);
    assign hit      = pend_reg && (cmd_reg == CMD_FIND) && rd_partial
                      && (rd_owner == pid_reg);
    assign scan_end = !pend_reg && (issue_reg >= scan_n);

    // Saturating offset update used by occupy.
    assign sum        = SUM_W'(rd_offset) + SUM_W'(fill_reg);
    assign new_offset = (sum > SUM_W'(page_lim)) ? page_lim : OFF_W'(sum);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(MAX_FRAMES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.command) inside
                        CMD_FIND, CMD_COUNT:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_OCCUPY, CMD_RELEASE:
                        begin
                            state_next = idx_ok ? ST_READ : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (hit || scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        clr_next        = clr_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        have_free_next  = have_free_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        chk_next        = chk_reg;
        first_free_next = first_free_reg;
        res_next        = res_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {{(E_W-1){1'b0}}, 1'b1};
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next       = req.command;
                    pid_next       = PID_BITS'(req.process_id);
                    idx_next       = AW'(req.frame_index);
                    fill_next      = req.fill_bytes;
                    issue_next     = '0;
                    have_free_next = 1'b0;
                    cnt_next       = '0;
                    res_next       = '0;
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_MODIFY:
            begin
                mem_we = 1'b1;
                if (cmd_reg == CMD_OCCUPY)
                begin
                    mem_wdata = {pid_reg, new_offset, (new_offset < page_lim), 1'b0};
                end
                else
                begin
                    mem_wdata = {rd_owner, {OFF_W{1'b0}}, 1'b0, 1'b1};
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < scan_n)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = issue_reg[AW-1:0];
                    issue_next = issue_reg + 1'b1;
                    chk_next   = issue_reg[AW-1:0];
                    pend_next  = 1'b1;
                end
                if (pend_reg && rd_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (!have_free_reg)
                    begin
                        have_free_next  = 1'b1;
                        first_free_next = chk_reg;
                    end
                end
                if (hit)
                begin
                    res_next.found       = 1'b1;
                    res_next.found_frame = 6'(chk_reg);
                    res_next.hole_start  = 13'(rd_offset);
                end
                else if (scan_end)
                begin
                    if (cmd_reg == CMD_COUNT)
                    begin
                        res_next.free_frames = 7'(cnt_reg);
                    end
                    else if (have_free_reg)
                    begin
                        res_next.found       = 1'b1;
                        res_next.found_frame = 6'(first_free_reg);
                    end
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            have_free_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            have_free_reg <= have_free_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pid_reg        <= pid_next;
        idx_reg        <= idx_next;
        fill_reg       <= fill_next;
        chk_reg        <= chk_next;
        first_free_reg <= first_free_next;
        res_reg        <= res_next;
    end

    // Table writes come only from the clearing pass or an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR) || (state_reg == ST_MODIFY))
        else $error("frame table written outside clear or update");

    // A pending check always follows a read issued in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(mem_re))
        else $error("scan check without a matching read");

    // Only a find can report a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (cmd_reg == CMD_FIND))
        else $error("found set on a command other than find");

    // Only a count can report free frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (cmd_reg != CMD_COUNT)) |-> (res.free_frames == 7'd0))
        else $error("free frame count set on a command other than count");

endmodule

### rtl/page_frame_table_allocator.sv
// ----------------------------------------------------------------------------
// Page frame table allocator
// First-fit page frame table with find, occupy, release and count requests.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req) carries one command per
// request. The response channel (rsp_valid, rsp_ready, rsp) returns exactly
// one response per request, in order. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) sets the page size and the number of frames
// scanned; it is always ready. The user must see that it is written only
// while the block is idle; the block itself does not enforce this. After reset
// the table is cleared one frame per cycle, so req_ready stays low until
// every frame has been cleared. Find and count walk the table through a single
// memory read port at one frame per cycle. The scan covers frame_count
// frames, capped at MAX_FRAMES; a find ends early on a partly filled frame
// of the process. Occupy and release read and then write the same frame.
// One request is worked on at a time. A finished response sits in an
// output register, so a stalled receiver holds rsp steady and the next
// request is taken and worked on until its own response is ready.
// ----------------------------------------------------------------------------
module page_frame_table_allocator
    import pfta_pkg::*;
#(
    parameter int MAX_FRAMES     = DEF_MAX_FRAMES,
    parameter int MAX_PAGE_BYTES = DEF_MAX_PAGE_BYTES,
    parameter int PID_BITS       = DEF_PID_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW    = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int OFF_W = $clog2(MAX_PAGE_BYTES + 1);
    localparam int E_W   = PID_BITS + OFF_W + 2;

    logic [12:0]      page_size_reg;
    logic [6:0]       frame_count_reg;
    logic [OFF_W-1:0] page_lim;
    logic [CNT_W-1:0] scan_n;

    logic             res_valid;
    logic             res_ready;
    rsp_t             res;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [E_W-1:0]   mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [E_W-1:0]   mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RESET;
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAGE_SIZE:
                begin
                    page_size_reg <= cfg_data[12:0];
                end
                CFG_FRAME_COUNT:
                begin
                    frame_count_reg <= cfg_data[6:0];
                end
                default:
                begin
                    page_size_reg <= page_size_reg;
                end
            endcase
        end
    end

    assign page_lim = (32'(page_size_reg) > MAX_PAGE_BYTES) ? OFF_W'(MAX_PAGE_BYTES)
                                                             : OFF_W'(page_size_reg);
    assign scan_n   = (32'(frame_count_reg) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES)
                                                           : CNT_W'(frame_count_reg);

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    pfta_ctrl #(
        .MAX_FRAMES     (MAX_FRAMES),
        .MAX_PAGE_BYTES (MAX_PAGE_BYTES),
        .PID_BITS       (PID_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .page_lim  (page_lim),
        .scan_n    (scan_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pfta_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (E_W)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule
